FILE: design/bfra_pkg.sv
// Package for the best-fit coalescing range allocator.
// Holds request/response structs, action and status codes, FSM states.
// No dependencies.
package bfra_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned AddrBitsDef     = 48;
  localparam int unsigned FieldBits       = 48;
  localparam int unsigned ShiftBits       = 5;
  localparam logic [ShiftBits-1:0] ShiftReset = 5'd12;
  localparam logic [ShiftBits-1:0] ShiftMin   = 5'd12;
  localparam logic [ShiftBits-1:0] ShiftMax   = 5'd16;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_BAD   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADREQ = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]           action;
    logic [FieldBits-1:0] range_start;
    logic [FieldBits-1:0] byte_count;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [FieldBits-1:0] grant_start;
    logic [FieldBits-1:0] grant_size;
  } rsp_t;

endpackage

FILE: design/best_fit_coalescing_range_allocator.sv
// One request at a time: busy is high from S_SCAN through S_DONE, and a new
// request is taken only in S_IDLE. The scan walks one table entry per cycle
// through a single shared compare unit, then passes through S_UPDATE and
// S_DONE, where the done strobe is raised. Results cannot be stalled.
// Reset (async, active low) clears valid bits, page shift to 12; range storage is
// left undefined until written. Depends on bfra_pkg.
module best_fit_coalescing_range_allocator #(
  parameter int unsigned TABLE_ENTRIES = bfra_pkg::TableEntriesDef,
  parameter int unsigned ADDR_BITS     = bfra_pkg::AddrBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bfra_pkg::req_t                req_i,
  output logic                          done_o,
  output bfra_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bfra_pkg::ShiftBits-1:0] cfg_wdata_i
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned FB   = bfra_pkg::FieldBits;
  localparam int unsigned SB   = bfra_pkg::ShiftBits;

  typedef logic [ADDR_BITS-1:0] addr_t;

  // Control
  bfra_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SB-1:0]    shift_q;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  // Request latch
  logic [1:0] act_q;
  addr_t      start_q, len_q, need_q, end_q;
  logic       big_q;

  // Scan results
  logic       best_ok_q, prev_ok_q, next_ok_q, empty_ok_q;
  logic [IdxW-1:0] best_q, prev_q, next_q, empty_q;
  addr_t      best_s_q, best_l_q, prev_l_q, next_l_q;
  logic [1:0] stat_q;
  addr_t      gs_q, gz_q;
  logic [1:0] stat_w;

  // Storage, one entry each
  addr_t fs_q [TABLE_ENTRIES];
  addr_t fl_q [TABLE_ENTRIES];

  // Write port
  logic      wr_en;
  logic [IdxW-1:0] wr_idx;
  addr_t     wr_s, wr_l;

  // Page rounding of incoming count
  logic [SB-1:0] sh;
  logic [ADDR_BITS:0] pmask, need_w;
  addr_t cnt_in, st_in;
  always_comb begin
    sh = shift_q;
    if (sh < bfra_pkg::ShiftMin) sh = bfra_pkg::ShiftMin;
    if (sh > bfra_pkg::ShiftMax) sh = bfra_pkg::ShiftMax;
    pmask  = ((ADDR_BITS+1)'(1) << sh) - (ADDR_BITS+1)'(1);
    cnt_in = ADDR_BITS'(req_i.byte_count);
    st_in  = ADDR_BITS'(req_i.range_start);
    need_w = ({1'b0, cnt_in} + pmask) & ~pmask;
  end

  assign busy = (state_q != bfra_pkg::S_IDLE);

  // Shared compare unit on the current entry
  logic [IdxW-1:0] ci;
  addr_t ent_s, ent_l, ent_e;
  logic  ent_v, fits, better;
  always_comb begin
    ci    = cnt_q[IdxW-1:0];
    ent_v = valid_q[ci];
    ent_s = fs_q[ci];
    ent_l = fl_q[ci];
    ent_e = ent_s + ent_l;
    fits  = ent_v && (ent_l >= need_q);
    better = !best_ok_q || (ent_l < best_l_q) ||
             ((ent_l == best_l_q) && (ent_s < best_s_q));
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = valid_q;
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_s    = '0;
    wr_l    = '0;
    unique case (state_q)
      bfra_pkg::S_IDLE: begin
        cnt_d = '0;
        if (start) state_d = bfra_pkg::S_SCAN;
      end
      bfra_pkg::S_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TABLE_ENTRIES - 1)) state_d = bfra_pkg::S_UPDATE;
      end
      bfra_pkg::S_UPDATE: begin
        state_d = bfra_pkg::S_DONE;
        if (stat_w == bfra_pkg::ST_OK) begin
          unique case (act_q)
            bfra_pkg::ACT_ALLOC: begin
              if (!big_q && best_ok_q) begin
                if (best_l_q < (need_q << 1) || need_q[ADDR_BITS-1]) begin
                  valid_d[best_q] = 1'b0;
                end else begin
                  wr_en = 1'b1; wr_idx = best_q;
                  wr_s = best_s_q + need_q; wr_l = best_l_q - need_q;
                end
              end
            end
            bfra_pkg::ACT_FREE: begin
              if (len_q != '0) begin
                if (prev_ok_q && next_ok_q && next_q != prev_q) begin
                  wr_en = 1'b1; wr_idx = prev_q; wr_s = fs_q[prev_q];
                  wr_l = prev_l_q + len_q + next_l_q;
                  valid_d[next_q] = 1'b0;
                end else if (prev_ok_q) begin
                  wr_en = 1'b1; wr_idx = prev_q; wr_s = fs_q[prev_q];
                  wr_l = prev_l_q + len_q;
                end else if (next_ok_q) begin
                  wr_en = 1'b1; wr_idx = next_q; wr_s = start_q;
                  wr_l = next_l_q + len_q;
                end else if (empty_ok_q) begin
                  wr_en = 1'b1; wr_idx = empty_q; wr_s = start_q; wr_l = len_q;
                  valid_d[empty_q] = 1'b1;
                end
              end
            end
            bfra_pkg::ACT_ADD: begin
              if (len_q != '0 && empty_ok_q) begin
                wr_en = 1'b1; wr_idx = empty_q; wr_s = start_q; wr_l = len_q;
                valid_d[empty_q] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      bfra_pkg::S_DONE: state_d = bfra_pkg::S_IDLE;
      default: state_d = bfra_pkg::S_IDLE;
    endcase
  end

  // Final status from scan results
  always_comb begin
    stat_w = bfra_pkg::ST_OK;
    case (act_q)
      bfra_pkg::ACT_ALLOC: begin
        if (len_q == '0) stat_w = bfra_pkg::ST_BADREQ;
        else if (big_q || !best_ok_q) stat_w = bfra_pkg::ST_NOFIT;
      end
      bfra_pkg::ACT_FREE: begin
        if (len_q != '0 && !prev_ok_q && !next_ok_q && !empty_ok_q)
          stat_w = bfra_pkg::ST_FULL;
      end
      bfra_pkg::ACT_ADD: begin
        if (len_q != '0 && !empty_ok_q) stat_w = bfra_pkg::ST_FULL;
      end
      default: stat_w = bfra_pkg::ST_BADREQ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfra_pkg::S_IDLE;
      cnt_q   <= '0;
      valid_q <= '0;
      shift_q <= bfra_pkg::ShiftReset;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      if (cfg_we_i) shift_q <= cfg_wdata_i;
    end
  end

  // Table write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fs_q[wr_idx] <= wr_s;
      fl_q[wr_idx] <= wr_l;
    end
  end

  // Latch request, scan, finish
  always_ff @(posedge clk_i) begin
    if (state_q == bfra_pkg::S_IDLE && start) begin
      act_q   <= req_i.action;
      start_q <= st_in;
      len_q   <= cnt_in;
      need_q  <= need_w[ADDR_BITS-1:0];
      big_q   <= need_w[ADDR_BITS];
      end_q   <= st_in + cnt_in;
      best_ok_q <= 1'b0; prev_ok_q <= 1'b0; next_ok_q <= 1'b0; empty_ok_q <= 1'b0;
    end
    if (state_q == bfra_pkg::S_SCAN) begin
      if (fits && better) begin
        best_ok_q <= 1'b1; best_q <= ci; best_s_q <= ent_s; best_l_q <= ent_l;
      end
      if (ent_v && !prev_ok_q && ent_e == start_q) begin
        prev_ok_q <= 1'b1; prev_q <= ci; prev_l_q <= ent_l;
      end
      if (ent_v && !next_ok_q && ent_s == end_q) begin
        next_ok_q <= 1'b1; next_q <= ci; next_l_q <= ent_l;
      end
      if (!ent_v && !empty_ok_q) begin
        empty_ok_q <= 1'b1; empty_q <= ci;
      end
    end
    if (state_q == bfra_pkg::S_UPDATE) begin
      stat_q <= stat_w;
      if (stat_w == bfra_pkg::ST_OK && act_q == bfra_pkg::ACT_ALLOC) begin
        gs_q <= best_s_q;
        gz_q <= (best_l_q < (need_q << 1) || need_q[ADDR_BITS-1]) ? best_l_q : need_q;
      end else begin
        gs_q <= '0;
        gz_q <= '0;
      end
    end
  end

  // Result strobe
  assign done_o = (state_q == bfra_pkg::S_DONE);
  always_comb begin
    rsp_o.status      = stat_q;
    rsp_o.grant_start = FB'(gs_q);
    rsp_o.grant_size  = FB'(gz_q);
  end

endmodule

FILE: design/bfra_checker.sv
// Port-level checker for the range allocator, bound to the top level.
// Depends on bfra_pkg.
module bfra_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bfra_pkg::rsp_t rsp_o
);
  // Accepted request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("not busy after request");
  // Done only while busy
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy) else $error("done while idle");
  // Done is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("done held");
  // Failed results carry zero grant
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && rsp_o.status != bfra_pkg::ST_OK) |->
      (rsp_o.grant_start == '0 && rsp_o.grant_size == '0))
    else $error("grant on failure");
endmodule

bind best_fit_coalescing_range_allocator bfra_checker u_bfra_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .done(done_o), .rsp_o(rsp_o)
);
